// ===== src/brq_pkg.sv =====
// Shared types, codes and sizing for the backoff retry queue.
// No dependencies; the files that use it refer to it by scoped names.
`default_nettype none
package brq_pkg;

  localparam int QUEUE_DEPTH = 64;
  localparam int SHIFT_CAP   = 20;

  localparam int IDX_W   = $clog2(QUEUE_DEPTH);
  localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int SH_W    = $clog2(SHIFT_CAP + 1);
  localparam int WIDE_W  = 32 + SHIFT_CAP;
  localparam int DUE_W   = 41;
  localparam int ENTRY_W = 16 + 8 + DUE_W;

  // input modes
  localparam logic [1:0] MODE_ENQUEUE = 2'd0;
  localparam logic [1:0] MODE_POP     = 2'd1;
  localparam logic [1:0] MODE_REQUEUE = 2'd2;

  // result status codes
  localparam logic [2:0] ST_QUEUED   = 3'd0;
  localparam logic [2:0] ST_DISABLED = 3'd1;
  localparam logic [2:0] ST_GAVE_UP  = 3'd2;
  localparam logic [2:0] ST_NOTHING  = 3'd3;
  localparam logic [2:0] ST_POPPED   = 3'd4;

  // configuration register indexes
  localparam logic [2:0] CFG_BASE_DELAY  = 3'd0;
  localparam logic [2:0] CFG_MAX_DELAY   = 3'd1;
  localparam logic [2:0] CFG_MAX_ATTEMPT = 3'd2;
  localparam logic [2:0] CFG_MAX_ENTRIES = 3'd3;
  localparam logic [2:0] CFG_JITTER      = 3'd4;

  typedef struct packed {
    logic       load;    // capture an accepted beat
    logic       commit;  // finish the item and fill the output register
    logic       push;
    logic       pop;
    logic       drop;
    logic [2:0] status;
  } brq_cmd_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       retry_off;
    logic       limit_hit;
    logic       nonempty;
    logic       head_due;
    logic       full;
  } brq_sts_t;

endpackage
`default_nettype wire

// ===== src/brq_in_if.sv =====
// Input channel: valid/ready handshake carrying one retry request.
// Uses no package items.
`default_nettype none
interface brq_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [15:0] batch_id;
  logic [7:0]  attempts_in;
  logic [39:0] now_ms;
  logic [15:0] jitter_draw;

  modport source (output valid, mode, batch_id, attempts_in, now_ms, jitter_draw,
                  input ready);
  modport sink   (input valid, mode, batch_id, attempts_in, now_ms, jitter_draw,
                  output ready);
endinterface
`default_nettype wire

// ===== src/brq_out_if.sv =====
// Result channel: valid/ready handshake carrying one result beat.
// Uses no package items.
`default_nettype none
interface brq_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [15:0] out_batch_id;
  logic [7:0]  out_attempts;
  logic        dropped_oldest;
  logic [15:0] dropped_batch_id;

  modport source (output valid, status, out_batch_id, out_attempts, dropped_oldest,
                  dropped_batch_id, input ready);
  modport sink   (input valid, status, out_batch_id, out_attempts, dropped_oldest,
                  dropped_batch_id, output ready);
endinterface
`default_nettype wire

// ===== src/brq_cfg_if.sv =====
// Configuration write channel: valid/ready, register index and write data.
// Uses no package items.
`default_nettype none
interface brq_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== src/brq_ctrl.sv =====
// Controller for the retry queue: two-state sequencer and outcome decision.
// Depends on brq_pkg for the command/status structs and codes.
`default_nettype none
module brq_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  input  wire brq_pkg::brq_sts_t sts,
  output brq_pkg::brq_cmd_t      cmd
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state;
  logic state_next;
  logic out_valid_next;
  logic can_finish;

  assign in_ready   = (state == S_IDLE);
  assign can_finish = (state == S_EXEC) && (!out_valid || out_ready);

  always_comb begin
    cmd        = '0;
    cmd.status = brq_pkg::ST_NOTHING;
    cmd.load   = in_valid && in_ready;
    cmd.commit = can_finish;
    unique case (sts.mode)
      brq_pkg::MODE_ENQUEUE: begin
        if (sts.retry_off) begin
          cmd.status = brq_pkg::ST_DISABLED;
        end else begin
          cmd.status = brq_pkg::ST_QUEUED;
          cmd.push   = can_finish;
          cmd.drop   = can_finish && sts.full;
        end
      end
      brq_pkg::MODE_POP: begin
        if (sts.nonempty && sts.head_due) begin
          cmd.status = brq_pkg::ST_POPPED;
          cmd.pop    = can_finish;
        end
      end
      brq_pkg::MODE_REQUEUE: begin
        if (sts.retry_off) begin
          cmd.status = brq_pkg::ST_DISABLED;
        end else if (sts.limit_hit) begin
          cmd.status = brq_pkg::ST_GAVE_UP;
        end else begin
          cmd.status = brq_pkg::ST_QUEUED;
          cmd.push   = can_finish;
          cmd.drop   = can_finish && sts.full;
        end
      end
      default: begin
        cmd.status = brq_pkg::ST_NOTHING;
      end
    endcase
  end

  always_comb begin
    state_next     = state;
    out_valid_next = out_valid;
    if (out_valid && out_ready) out_valid_next = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_EXEC;
      end
      S_EXEC: begin
        if (can_finish) begin
          state_next     = S_IDLE;
          out_valid_next = 1'b1;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule
`default_nettype wire

// ===== src/brq_dp.sv =====
// Datapath for the retry queue: config registers, backoff arithmetic,
// entry memory with head/tail pointers and the output register. Uses brq_pkg.
`default_nettype none
module brq_dp (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_valid,
  input  wire logic [2:0]        cfg_index,
  input  wire logic [31:0]       cfg_data,
  input  wire logic [1:0]        mode,
  input  wire logic [15:0]       batch_id,
  input  wire logic [7:0]        attempts_in,
  input  wire logic [39:0]       now_ms,
  input  wire logic [15:0]       jitter_draw,
  input  wire brq_pkg::brq_cmd_t cmd,
  output brq_pkg::brq_sts_t      sts,
  output logic [2:0]             status,
  output logic [15:0]            out_batch_id,
  output logic [7:0]             out_attempts,
  output logic                   dropped_oldest,
  output logic [15:0]            dropped_batch_id
);

  // configuration
  logic [31:0] base_delay;
  logic [31:0] max_delay;
  logic [7:0]  attempt_limit;
  logic [6:0]  max_queue_entries;
  logic [15:0] jitter_cap;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_delay        <= 32'd100;
      max_delay         <= 32'd30000;
      attempt_limit     <= 8'd5;
      max_queue_entries <= 7'd64;
      jitter_cap        <= 16'd0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        brq_pkg::CFG_BASE_DELAY:  base_delay        <= cfg_data;
        brq_pkg::CFG_MAX_DELAY:   max_delay         <= cfg_data;
        brq_pkg::CFG_MAX_ATTEMPT: attempt_limit     <= cfg_data[7:0];
        brq_pkg::CFG_MAX_ENTRIES: max_queue_entries <= cfg_data[6:0];
        brq_pkg::CFG_JITTER:      jitter_cap        <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // first stage: shift, cap and jitter clamp straight off the input beat
  logic [brq_pkg::SH_W-1:0]   shift_amt;
  logic [brq_pkg::WIDE_W-1:0] wide_delay;
  logic [31:0]                capped_delay;
  logic [15:0]                jitter_use;
  logic [7:0]                 next_att;

  always_comb begin
    shift_amt = '0;
    next_att  = 8'd1;
    if (mode == brq_pkg::MODE_REQUEUE && attempts_in != 8'd0) begin
      next_att = attempts_in + 8'd1;
      if (int'(attempts_in) > brq_pkg::SHIFT_CAP) begin
        shift_amt = brq_pkg::SH_W'(brq_pkg::SHIFT_CAP);
      end else begin
        shift_amt = brq_pkg::SH_W'(attempts_in);
      end
    end
    wide_delay   = brq_pkg::WIDE_W'(base_delay) << shift_amt;
    capped_delay = (wide_delay > brq_pkg::WIDE_W'(max_delay)) ?
                   max_delay : wide_delay[31:0];
    jitter_use   = (jitter_draw < jitter_cap) ? jitter_draw : jitter_cap;
  end

  logic [1:0]  mode_r;
  logic [15:0] batch_r;
  logic [7:0]  att_r;
  logic [7:0]  next_att_r;
  logic [39:0] now_r;
  logic [31:0] delay_r;
  logic [15:0] jitter_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r     <= mode;
      batch_r    <= batch_id;
      att_r      <= attempts_in;
      next_att_r <= next_att;
      now_r      <= now_ms;
      delay_r    <= capped_delay;
      jitter_r   <= jitter_use;
    end
  end

  // entry store and pointers
  logic [brq_pkg::ENTRY_W-1:0] mem [brq_pkg::QUEUE_DEPTH];
  logic [brq_pkg::ENTRY_W-1:0] head_q;
  logic [brq_pkg::IDX_W-1:0]   head_index;
  logic [brq_pkg::IDX_W-1:0]   tail_index;
  logic [brq_pkg::CNT_W-1:0]   entry_count;

  logic [15:0]               head_batch;
  logic [7:0]                head_att;
  logic [brq_pkg::DUE_W-1:0] head_due_time;
  logic [brq_pkg::DUE_W-1:0] due_time;

  assign {head_batch, head_att, head_due_time} = head_q;
  assign due_time = brq_pkg::DUE_W'(now_r) + brq_pkg::DUE_W'(delay_r)
                  + brq_pkg::DUE_W'(jitter_r);

  always_ff @(posedge clk) begin
    if (cmd.push) mem[tail_index] <= {batch_r, next_att_r, due_time};
  end

  // head is stable between items, so read it as the beat is taken
  always_ff @(posedge clk) begin
    if (cmd.load) head_q <= mem[head_index];
  end

  function automatic logic [brq_pkg::IDX_W-1:0] wrap_next(
    input logic [brq_pkg::IDX_W-1:0] i
  );
    return (i == brq_pkg::IDX_W'(brq_pkg::QUEUE_DEPTH - 1)) ? '0 : i + 1'b1;
  endfunction

  logic advance_head;
  assign advance_head = cmd.pop || cmd.drop;

  always_ff @(posedge clk) begin
    if (rst) begin
      head_index  <= '0;
      tail_index  <= '0;
      entry_count <= '0;
    end else begin
      if (advance_head) head_index <= wrap_next(head_index);
      if (cmd.push) tail_index <= wrap_next(tail_index);
      // a drop and a push together leave the count unchanged
      if (cmd.push && !advance_head) begin
        entry_count <= entry_count + 1'b1;
      end else if (!cmd.push && advance_head) begin
        entry_count <= entry_count - 1'b1;
      end
    end
  end

  // occupancy limit, clamped to 1..QUEUE_DEPTH
  logic [brq_pkg::CNT_W-1:0] limit;
  always_comb begin
    if (max_queue_entries == 7'd0) begin
      limit = brq_pkg::CNT_W'(1);
    end else if (int'(max_queue_entries) > brq_pkg::QUEUE_DEPTH) begin
      limit = brq_pkg::CNT_W'(brq_pkg::QUEUE_DEPTH);
    end else begin
      limit = brq_pkg::CNT_W'(max_queue_entries);
    end
  end

  always_comb begin
    sts.mode      = mode_r;
    sts.retry_off = (attempt_limit == 8'd0);
    sts.limit_hit = (att_r >= attempt_limit);
    sts.nonempty  = (entry_count != '0);
    sts.head_due  = (head_due_time <= brq_pkg::DUE_W'(now_r));
    sts.full      = (entry_count >= limit);
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      status           <= cmd.status;
      out_batch_id     <= cmd.pop  ? head_batch : 16'd0;
      out_attempts     <= cmd.pop  ? head_att   : 8'd0;
      dropped_oldest   <= cmd.drop;
      dropped_batch_id <= cmd.drop ? head_batch : 16'd0;
    end
  end

endmodule
`default_nettype wire

// ===== src/backoff_retry_queue.sv =====
// Top level of the backoff retry queue: joins controller and datapath.
// Depends on brq_pkg, brq_in_if, brq_out_if, brq_cfg_if, brq_ctrl, brq_dp.
//
// Usage:
//   in_ch   request beats: mode (enqueue, pop if due, requeue), batch_id,
//           attempts_in, now_ms and a random jitter_draw.
//   out_ch  one result beat per request: status, popped handle and attempt
//           count, and the handle of any oldest entry dropped to make room.
//   cfg     register writes (index, data); always ready, applied next edge.
//           Write only while no request is in flight.
// Timing: a request is taken in the idle state and its result is registered
//   at the end of the exec state that follows, once the result register is
//   free; a new request is taken only after the last result is registered.
//   The backoff path runs shift and cap in the accept cycle, then the due-time add and the entry RAM write.
// The head entry is read from the RAM as the beat is accepted.
// A stalled receiver holds the result register; the next request may still be
//   accepted, but it waits in the exec state until the result is taken.
// Reset (rst, synchronous) empties the queue and restores the register
//   defaults; the entry RAM itself is not cleared.
`default_nettype none
module backoff_retry_queue (
  input wire logic  clk,
  input wire logic  rst,
  brq_in_if.sink    in_ch,
  brq_out_if.source out_ch,
  brq_cfg_if.sink   cfg
);

  brq_pkg::brq_cmd_t cmd;
  brq_pkg::brq_sts_t sts;

  assign cfg.ready = 1'b1;

  brq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  brq_dp u_dp (
    .clk              (clk),
    .rst              (rst),
    .cfg_valid        (cfg.valid),
    .cfg_index        (cfg.index),
    .cfg_data         (cfg.data),
    .mode             (in_ch.mode),
    .batch_id         (in_ch.batch_id),
    .attempts_in      (in_ch.attempts_in),
    .now_ms           (in_ch.now_ms),
    .jitter_draw      (in_ch.jitter_draw),
    .cmd              (cmd),
    .sts              (sts),
    .status           (out_ch.status),
    .out_batch_id     (out_ch.out_batch_id),
    .out_attempts     (out_ch.out_attempts),
    .dropped_oldest   (out_ch.dropped_oldest),
    .dropped_batch_id (out_ch.dropped_batch_id)
  );

endmodule
`default_nettype wire

// ===== src/brq_checker.sv =====
// Port-level checks for the backoff retry queue, bound to the top level.
// Depends on brq_pkg for status codes.
`default_nettype none
module brq_port_checks (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [2:0]  status,
  input wire logic [15:0] out_batch_id,
  input wire logic [7:0]  out_attempts,
  input wire logic        dropped_oldest,
  input wire logic [15:0] dropped_batch_id
);

  // a held result beat stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat withdrawn while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result offered straight after reset");

  // one item at a time: no beat taken in the cycle after one was taken
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second beat accepted while an item is in flight");

  a_pop_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != brq_pkg::ST_POPPED |->
      out_batch_id == 16'd0 && out_attempts == 8'd0)
    else $error("popped fields set on a non-pop result");

  a_drop_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && dropped_oldest |-> status == brq_pkg::ST_QUEUED)
    else $error("drop reported without an insert");

  a_drop_id: assert property (@(posedge clk) disable iff (rst)
    out_valid && !dropped_oldest |-> dropped_batch_id == 16'd0)
    else $error("dropped handle set without a drop");

endmodule

bind backoff_retry_queue brq_port_checks u_brq_port_checks (
  .clk              (clk),
  .rst              (rst),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .status           (out_ch.status),
  .out_batch_id     (out_ch.out_batch_id),
  .out_attempts     (out_ch.out_attempts),
  .dropped_oldest   (out_ch.dropped_oldest),
  .dropped_batch_id (out_ch.dropped_batch_id)
);
`default_nettype wire

// ===== dv/brq_checker.sv =====
// Checker for the backoff retry queue: watches the request, result and register channels,
// keeps its own model of the queue and compares every result beat with the prediction.
// Depends on brq_pkg and the brq_in_if, brq_out_if and brq_cfg_if interfaces.
`timescale 1ns / 100ps
module brq_checker (
  input wire logic clk,
  input wire logic rst,
  brq_in_if        in_ch,
  brq_out_if       out_ch,
  brq_cfg_if       cfg,
  output int       outstanding,
  output int       mismatches
);

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] batch;
    logic [7:0]  attempts;
    logic        dropped;
    logic [15:0] dropped_batch;
  } retry_result_t;

  // register copies
  logic [31:0] base_ms;
  logic [31:0] cap_ms;
  logic [7:0]  attempt_limit;
  logic [6:0]  entry_limit;
  logic [15:0] jitter_cap;

  // queue copy
  logic [15:0]               q_batch [brq_pkg::QUEUE_DEPTH];
  logic [7:0]                q_att   [brq_pkg::QUEUE_DEPTH];
  logic [brq_pkg::DUE_W-1:0] q_due   [brq_pkg::QUEUE_DEPTH];
  int head;
  int tail;
  int fill;

  retry_result_t expected_results[$];
  int err_count = 0;

  task automatic clear_state();
    base_ms       = 32'd100;
    cap_ms        = 32'd30000;
    attempt_limit = 8'd5;
    entry_limit   = 7'd64;
    jitter_cap    = 16'd0;
    head = 0;
    tail = 0;
    fill = 0;
    expected_results.delete();
  endtask

  task automatic write_setting(input logic [2:0] index, input logic [31:0] value);
    case (index)
      brq_pkg::CFG_BASE_DELAY:  base_ms       = value;
      brq_pkg::CFG_MAX_DELAY:   cap_ms        = value;
      brq_pkg::CFG_MAX_ATTEMPT: attempt_limit = value[7:0];
      brq_pkg::CFG_MAX_ENTRIES: entry_limit   = value[6:0];
      brq_pkg::CFG_JITTER:      jitter_cap    = value[15:0];
      default: ;
    endcase
  endtask

  // exponential part capped, then clamped jitter on top
  function automatic logic [brq_pkg::DUE_W-1:0] retry_delay(input logic [7:0] attempt,
                                                            input logic [15:0] draw);
    int shift;
    logic [brq_pkg::WIDE_W-1:0] scaled;
    logic [15:0] jit;
    shift = (attempt == 8'd0) ? 0 : int'(attempt) - 1;
    if (shift > brq_pkg::SHIFT_CAP) shift = brq_pkg::SHIFT_CAP;
    scaled = brq_pkg::WIDE_W'(base_ms) << shift;
    if (scaled > brq_pkg::WIDE_W'(cap_ms)) scaled = brq_pkg::WIDE_W'(cap_ms);
    jit = (draw < jitter_cap) ? draw : jitter_cap;
    return scaled[brq_pkg::DUE_W-1:0] + brq_pkg::DUE_W'(jit);
  endfunction

  task automatic store_retry(input logic [15:0] id, input logic [7:0] att,
                             input logic [brq_pkg::DUE_W-1:0] due,
                             inout retry_result_t res);
    int lim;
    lim = int'(entry_limit);
    if (lim == 0) lim = 1;
    if (lim > brq_pkg::QUEUE_DEPTH) lim = brq_pkg::QUEUE_DEPTH;
    // full: exactly one head entry goes, even if the limit was lowered below the fill
    if (fill >= lim && fill > 0) begin
      res.dropped       = 1'b1;
      res.dropped_batch = q_batch[head];
      head = (head + 1) % brq_pkg::QUEUE_DEPTH;
      fill--;
    end
    q_batch[tail] = id;
    q_att[tail]   = att;
    q_due[tail]   = due;
    tail = (tail + 1) % brq_pkg::QUEUE_DEPTH;
    fill++;
    res.status = brq_pkg::ST_QUEUED;
  endtask

  task automatic apply_request(input logic [1:0] mode, input logic [15:0] id,
                               input logic [7:0] att_in, input logic [39:0] now,
                               input logic [15:0] draw, output retry_result_t res);
    logic [7:0] next_att;
    res = '0;
    res.status = brq_pkg::ST_NOTHING;
    case (mode)
      brq_pkg::MODE_ENQUEUE: begin
        if (attempt_limit == 8'd0) res.status = brq_pkg::ST_DISABLED;
        else store_retry(id, 8'd1, brq_pkg::DUE_W'(now) + retry_delay(8'd1, draw), res);
      end
      brq_pkg::MODE_POP: begin
        if (fill > 0 && q_due[head] <= brq_pkg::DUE_W'(now)) begin
          res.status   = brq_pkg::ST_POPPED;
          res.batch    = q_batch[head];
          res.attempts = q_att[head];
          head = (head + 1) % brq_pkg::QUEUE_DEPTH;
          fill--;
        end
      end
      brq_pkg::MODE_REQUEUE: begin
        if (attempt_limit == 8'd0) begin
          res.status = brq_pkg::ST_DISABLED;
        end else if (att_in >= attempt_limit) begin
          res.status = brq_pkg::ST_GAVE_UP;
        end else begin
          next_att = (att_in == 8'd0) ? 8'd1 : att_in + 8'd1;
          store_retry(id, next_att,
                      brq_pkg::DUE_W'(now) + retry_delay(next_att, draw), res);
        end
      end
      default: ;
    endcase
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    err_count++;
    $display("brq_checker: %s: got %0h, expected %0h at %0t", what, got, want, $time);
  endtask

  always @(posedge clk) begin : watch
    retry_result_t got;
    retry_result_t want;
    retry_result_t predicted;
    if (rst) begin
      clear_state();
    end else begin
      if (cfg.valid && cfg.ready) write_setting(cfg.index, cfg.data);
      // compare before adding: a beat accepted now cannot be the answer to this edge's request
      if (out_ch.valid && out_ch.ready) begin
        got.status        = out_ch.status;
        got.batch         = out_ch.out_batch_id;
        got.attempts      = out_ch.out_attempts;
        got.dropped       = out_ch.dropped_oldest;
        got.dropped_batch = out_ch.dropped_batch_id;
        if (expected_results.size() == 0) begin
          report_mismatch("result beat with nothing outstanding", 64'(got), 64'd0);
        end else begin
          want = expected_results[0];
          expected_results.delete(0);
          if (got.status != want.status)
            report_mismatch("status", 64'(got.status), 64'(want.status));
          if (got.batch != want.batch)
            report_mismatch("out_batch_id", 64'(got.batch), 64'(want.batch));
          if (got.attempts != want.attempts)
            report_mismatch("out_attempts", 64'(got.attempts), 64'(want.attempts));
          if (got.dropped != want.dropped)
            report_mismatch("dropped_oldest", 64'(got.dropped), 64'(want.dropped));
          if (got.dropped_batch != want.dropped_batch)
            report_mismatch("dropped_batch_id", 64'(got.dropped_batch),
                            64'(want.dropped_batch));
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        apply_request(in_ch.mode, in_ch.batch_id, in_ch.attempts_in, in_ch.now_ms,
                      in_ch.jitter_draw, predicted);
        expected_results.insert(expected_results.size(), predicted);
      end
    end
    outstanding <= expected_results.size();
    mismatches  <= err_count;
  end

endmodule

// ===== dv/backoff_retry_queue_tb.sv =====
// Top of the backoff retry queue testbench: clock, reset, request and register stimulus.
// Depends on brq_pkg, the three channel interfaces, backoff_retry_queue and brq_checker.
`timescale 1ns / 100ps
module backoff_retry_queue_tb;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int STALL_LIMIT = 5000;
  localparam int PHASE_ITEMS = 215;
  localparam logic [39:0] NOW_MAX = 40'hFF_FFFF_FFFF;

  logic clk;
  logic rst;
  int pending;
  int mismatches;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int stall_cycles = 0;
  int att_limit = 5;
  int id_slot = 0;
  longint unsigned clock_ms = 0;
  longint unsigned step_ms = 2000;
  logic [15:0] recent_ids [16];

  brq_in_if  in_ch();
  brq_out_if out_ch();
  brq_cfg_if cfg();

  backoff_retry_queue u_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg    (cfg)
  );

  brq_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg         (cfg),
    .outstanding (pending),
    .mismatches  (mismatches)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // cycles since the last beat on any channel
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg.valid && cfg.ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
  end

  initial begin
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("tb: failure");
    $finish;
  end

  task automatic send_request(input logic [1:0] mode, input logic [15:0] id,
                              input logic [7:0] att, input logic [39:0] now,
                              input logic [15:0] draw);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.mode        <= mode;
    in_ch.batch_id    <= id;
    in_ch.attempts_in <= att;
    in_ch.now_ms      <= now;
    in_ch.jitter_draw <= draw;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] index, input logic [31:0] value);
    cfg.valid <= 1'b1;
    cfg.index <= index;
    cfg.data  <= value;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
  endtask

  task automatic wait_idle(input int settle);
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic apply_settings(input logic [31:0] base, input logic [31:0] cap,
                                input logic [7:0] attempts, input logic [6:0] entries,
                                input logic [15:0] jitter, input longint unsigned step);
    wait_idle(4);
    write_reg(brq_pkg::CFG_BASE_DELAY, base);
    write_reg(brq_pkg::CFG_MAX_DELAY, cap);
    write_reg(brq_pkg::CFG_MAX_ATTEMPT, 32'(attempts));
    write_reg(brq_pkg::CFG_MAX_ENTRIES, 32'(entries));
    write_reg(brq_pkg::CFG_JITTER, 32'(jitter));
    cfg.valid <= 1'b0;
    att_limit = int'(attempts);
    step_ms   = step;
  endtask

  // mostly a running clock with retries of recently queued batches; a tenth is raw noise
  task automatic random_request();
    int pick;
    int att_hi;
    longint unsigned adv;
    logic [1:0]  mode;
    logic [15:0] id;
    logic [7:0]  att;
    logic [39:0] now;
    logic [15:0] draw;
    pick = $urandom_range(99);
    id   = 16'($urandom);
    draw = 16'($urandom);
    if (pick < 10) begin
      mode = 2'($urandom);
      att  = 8'($urandom);
      now  = 40'({$urandom, $urandom});
    end else begin
      adv = {$urandom, $urandom};
      if (step_ms != 0) clock_ms += adv % (step_ms + 1);
      now = clock_ms[39:0];
      att_hi = att_limit + 1;
      if (att_hi > 255) att_hi = 255;
      att = 8'($urandom_range(att_hi));
      if (pick < 45) begin
        mode = brq_pkg::MODE_ENQUEUE;
      end else if (pick < 78) begin
        mode = brq_pkg::MODE_POP;
      end else begin
        mode = brq_pkg::MODE_REQUEUE;
        id   = recent_ids[$urandom_range(15)];
      end
    end
    if (mode == brq_pkg::MODE_ENQUEUE) begin
      recent_ids[id_slot] = id;
      id_slot = (id_slot + 1) % 16;
    end
    send_request(mode, id, att, now, draw);
  endtask

  initial begin
    for (int i = 0; i < 16; i++) recent_ids[i] = 16'd0;
    rst               <= 1'b1;
    in_ch.valid       <= 1'b0;
    in_ch.mode        <= brq_pkg::MODE_ENQUEUE;
    in_ch.batch_id    <= 16'd0;
    in_ch.attempts_in <= 8'd0;
    in_ch.now_ms      <= 40'd0;
    in_ch.jitter_draw <= 16'd0;
    cfg.valid         <= 1'b0;
    cfg.index         <= brq_pkg::CFG_BASE_DELAY;
    cfg.data          <= 32'd0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset settings first
    send_request(brq_pkg::MODE_POP, 16'h1234, 8'd1, 40'd0, 16'd0);        // empty queue
    send_request(MODE_UNUSED, 16'hFFFF, 8'hFF, NOW_MAX, 16'hFFFF);
    send_request(brq_pkg::MODE_ENQUEUE, 16'hFFFF, 8'd1, 40'd0, 16'hFFFF); // jitter off
    send_request(brq_pkg::MODE_ENQUEUE, 16'h0000, 8'd1, NOW_MAX, 16'd0);
    send_request(brq_pkg::MODE_POP, 16'd0, 8'd0, 40'd99, 16'd0);          // one short of due
    send_request(brq_pkg::MODE_POP, 16'd0, 8'd0, 40'd100, 16'd0);
    send_request(brq_pkg::MODE_REQUEUE, 16'hA5A5, 8'd0, 40'd200, 16'd0);  // zero attempts
    send_request(brq_pkg::MODE_REQUEUE, 16'h5A5A, 8'd4, 40'd200, 16'd7);
    send_request(brq_pkg::MODE_REQUEUE, 16'h0001, 8'd5, 40'd200, 16'd0);  // at the limit
    send_request(brq_pkg::MODE_REQUEUE, 16'h0002, 8'hFF, 40'd200, 16'd0);
    send_request(brq_pkg::MODE_POP, 16'd0, 8'd0, NOW_MAX, 16'd0);         // due past 2^40
    // widest delay, queue of two entries
    apply_settings(32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd255, 7'd2, 16'hFFFF, 0);
    send_request(brq_pkg::MODE_REQUEUE, 16'hBEEF, 8'd254, NOW_MAX, 16'hFFFF);
    send_request(brq_pkg::MODE_ENQUEUE, 16'hC0DE, 8'd1, 40'd0, 16'h8000);
    send_request(brq_pkg::MODE_POP, 16'd0, 8'd0, NOW_MAX, 16'd0);
    // retries off
    apply_settings(32'd100, 32'd30000, 8'd0, 7'd0, 16'd0, 0);
    send_request(brq_pkg::MODE_ENQUEUE, 16'h7777, 8'd1, 40'd5, 16'd0);
    send_request(brq_pkg::MODE_REQUEUE, 16'h7778, 8'd1, 40'd5, 16'd0);
    send_request(brq_pkg::MODE_POP, 16'd0, 8'd0, NOW_MAX, 16'd0);
    // zero delays, limit of zero entries acting as one
    apply_settings(32'd0, 32'd0, 8'd1, 7'd0, 16'd0, 0);
    send_request(brq_pkg::MODE_REQUEUE, 16'h1111, 8'd0, 40'd0, 16'hFFFF);
    send_request(brq_pkg::MODE_ENQUEUE, 16'h2222, 8'd1, 40'd0, 16'd0);
    send_request(brq_pkg::MODE_POP, 16'd0, 8'd0, 40'd0, 16'd0);
    send_request(brq_pkg::MODE_POP, 16'd0, 8'd0, 40'd0, 16'd0);

    for (int phase = 0; phase < 6; phase++) begin
      wait_idle(4);
      if (phase < 2) begin
        tx_idle_pct = 31;
        rx_idle_pct = 77;
      end else if (phase < 4) begin
        tx_idle_pct = 77;
        rx_idle_pct = 31;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      case (phase)
        0: apply_settings(32'd100, 32'd30000, 8'd5, 7'd64, 16'd0, 2000);
        1: apply_settings(32'd1, 32'hFFFF_FFFF, 8'd255, 7'd8, 16'hFFFF, 70000);
        2: apply_settings(32'd0, 32'd0, 8'd1, 7'd0, 16'd3, 4);
        3: apply_settings(32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd3, 7'd127, 16'd1000, 64'd1 << 32);
        4: apply_settings(32'd50, 32'd400, 8'd8, 7'd16, 16'd20, 300);
        default: apply_settings(32'($urandom_range(1000)), 32'($urandom_range(100000)),
                                8'($urandom_range(12)), 7'($urandom_range(127)),
                                16'($urandom), 20000);
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) random_request();
    end

    wait_idle(10);
    if (mismatches == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
